### src/ucd_pkg.sv
package ucd_pkg;

    localparam int unsigned SECS_W   = 40;
    localparam int unsigned DAYS_W   = 24;
    localparam int unsigned SOD_W    = 17;
    localparam int unsigned STAGES   = 13;

    typedef logic [SECS_W-1:0] secs_t;
    typedef logic [DAYS_W-1:0] days_t;
    typedef logic [SOD_W-1:0]  sod_t;
    typedef logic [STAGES-1:0] stage_en_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] sec;
    } hms_t;

    // seconds to days: 86400 = 128 * 675, numerator split at 2^16
    localparam int unsigned DAY_DIV   = 675;
    localparam int unsigned CHUNK     = 2**16;
    localparam int unsigned CHUNK_Q   = CHUNK / DAY_DIV;
    localparam int unsigned CHUNK_R   = CHUNK % DAY_DIV;
    localparam int unsigned K_DAY     = 23;
    localparam logic [13:0] RCP_DAY   = 14'((2**K_DAY) / DAY_DIV);

    // time of day
    localparam int unsigned SEC_HOUR  = 3600;
    localparam int unsigned SEC_MIN   = 60;
    localparam int unsigned K_HOUR    = 17;
    localparam logic [5:0]  RCP_HOUR  = 6'((2**K_HOUR) / SEC_HOUR);
    localparam int unsigned K_MIN     = 12;
    localparam logic [6:0]  RCP_MIN   = 7'((2**K_MIN) / SEC_MIN);

    // julian day formula
    localparam int unsigned OFS_A     = 102032;
    localparam int unsigned CYCLE_400 = 146097;
    localparam int unsigned K_A       = 26;
    localparam logic [8:0]  RCP_A     = 9'((2**K_A) / CYCLE_400);
    localparam int unsigned OFS_A2    = 15;
    localparam int unsigned OFS_B     = 2442113;
    localparam int unsigned OFS_C     = 2442;
    localparam int unsigned DIV_C     = 7305;
    localparam int unsigned K_C       = 29;
    localparam logic [16:0] RCP_C     = 17'((2**K_C) / DIV_C);
    localparam int unsigned DIV_E     = 30601;
    localparam int unsigned K_E       = 20;
    localparam logic [5:0]  RCP_E     = 6'((2**K_E) / DIV_E);
    localparam int unsigned YEAR_LO   = 4716;
    localparam int unsigned YEAR_HI   = 4715;
    localparam int unsigned E_SPLIT   = 13;

    // 30*e + (601*e)/1000
    localparam logic [9:0] MONTH_OFS [0:15] = '{
        10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
        10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459
    };

endpackage

### src/ucd_day_split.sv
module ucd_day_split (
    input  logic              clk,
    input  ucd_pkg::stage_en_t en,
    input  ucd_pkg::secs_t    secs,
    output ucd_pkg::days_t    days,
    output ucd_pkg::sod_t     sod
);

    ucd_pkg::secs_t  t0_reg;
    logic [22:0]     x1_reg, x2_reg;
    ucd_pkg::days_t  dh1_reg, dh2_reg;
    logic [6:0]      lo1_reg, lo2_reg;
    logic [13:0]     q2_reg;
    ucd_pkg::days_t  days3_reg;
    ucd_pkg::sod_t   sod3_reg;

    logic [16:0]     hi;
    logic [15:0]     lo;
    logic [22:0]     x1_next;
    ucd_pkg::days_t  dh1_next;
    logic [36:0]     prod2;
    logic [22:0]     r_raw;
    logic [13:0]     q_fix;
    logic [9:0]      r_fix;

    always_comb
    begin
        hi       = t0_reg[39:23];
        lo       = t0_reg[22:7];
        x1_next  = 23'(hi) * 23'(ucd_pkg::CHUNK_R) + 23'(lo);
        dh1_next = 24'(hi) * 24'(ucd_pkg::CHUNK_Q);
        prod2    = 37'(x1_reg) * 37'(ucd_pkg::RCP_DAY);
        r_raw    = x2_reg - 23'(q2_reg) * 23'(ucd_pkg::DAY_DIV);
        if (r_raw >= 23'(ucd_pkg::DAY_DIV))
        begin
            q_fix = q2_reg + 14'd1;
            r_fix = 10'(r_raw - 23'(ucd_pkg::DAY_DIV));
        end
        else
        begin
            q_fix = q2_reg;
            r_fix = 10'(r_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t0_reg <= secs;
        end
        if (en[1])
        begin
            x1_reg  <= x1_next;
            dh1_reg <= dh1_next;
            lo1_reg <= t0_reg[6:0];
        end
        if (en[2])
        begin
            q2_reg  <= prod2[36:23];
            x2_reg  <= x1_reg;
            dh2_reg <= dh1_reg;
            lo2_reg <= lo1_reg;
        end
        if (en[3])
        begin
            days3_reg <= dh2_reg + 24'(q_fix);
            sod3_reg  <= {r_fix, lo2_reg};
        end
    end

    assign days = days3_reg;
    assign sod  = sod3_reg;

endmodule

### src/ucd_clock_split.sv
module ucd_clock_split (
    input  logic              clk,
    input  ucd_pkg::stage_en_t en,
    input  ucd_pkg::sod_t     sod,
    output ucd_pkg::hms_t     hms
);

    ucd_pkg::sod_t   sod4_reg;
    logic [4:0]      hq4_reg, hour5_reg, hour6_reg;
    logic [11:0]     rh5_reg, rh6_reg;
    logic [5:0]      mq6_reg;
    ucd_pkg::hms_t   dly_reg [7:12];

    logic [22:0]     prod4;
    logic [16:0]     rh_raw;
    logic [4:0]      hour_fix;
    logic [11:0]     rh_fix;
    logic [18:0]     prod6;
    logic [11:0]     rm_raw;
    ucd_pkg::hms_t   hms7_next;

    always_comb
    begin
        prod4  = 23'(sod) * 23'(ucd_pkg::RCP_HOUR);
        rh_raw = sod4_reg - 17'(hq4_reg) * 17'(ucd_pkg::SEC_HOUR);
        if (rh_raw >= 17'(ucd_pkg::SEC_HOUR))
        begin
            hour_fix = hq4_reg + 5'd1;
            rh_fix   = 12'(rh_raw - 17'(ucd_pkg::SEC_HOUR));
        end
        else
        begin
            hour_fix = hq4_reg;
            rh_fix   = 12'(rh_raw);
        end
        prod6  = 19'(rh5_reg) * 19'(ucd_pkg::RCP_MIN);
        rm_raw = rh6_reg - 12'(mq6_reg) * 12'(ucd_pkg::SEC_MIN);
        hms7_next.hour = hour6_reg;
        if (rm_raw >= 12'(ucd_pkg::SEC_MIN))
        begin
            hms7_next.minute = mq6_reg + 6'd1;
            hms7_next.sec    = 6'(rm_raw - 12'(ucd_pkg::SEC_MIN));
        end
        else
        begin
            hms7_next.minute = mq6_reg;
            hms7_next.sec    = 6'(rm_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sod4_reg <= sod;
            hq4_reg  <= prod4[21:17];
        end
        if (en[5])
        begin
            hour5_reg <= hour_fix;
            rh5_reg   <= rh_fix;
        end
        if (en[6])
        begin
            hour6_reg <= hour5_reg;
            rh6_reg   <= rh5_reg;
            mq6_reg   <= prod6[17:12];
        end
        if (en[7])
        begin
            dly_reg[7] <= hms7_next;
        end
        for (int i = 8; i <= 12; i++)
        begin
            if (en[i])
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign hms = dly_reg[12];

endmodule

### src/ucd_date_calc.sv
module ucd_date_calc (
    input  logic              clk,
    input  ucd_pkg::stage_en_t en,
    input  ucd_pkg::days_t    days,
    output logic [15:0]       year,
    output logic [3:0]        month,
    output logic [4:0]        day
);

    logic [25:0]     na4_reg;
    logic [8:0]      qa4_reg;
    ucd_pkg::days_t  d4_reg, b5_reg, b6_reg, b7_reg;
    logic [28:0]     nc6_reg;
    logic [15:0]     qc6_reg, c7_reg, c8_reg, c9_reg, c10_reg, c11_reg;
    logic [9:0]      dd8_reg, dd9_reg, dd10_reg, dd11_reg;
    logic [19:0]     ne9_reg, ne10_reg;
    logic [5:0]      qe10_reg;
    logic [3:0]      e11_reg;
    logic [15:0]     year_reg;
    logic [3:0]      month_reg;
    logic [4:0]      day_reg;

    logic [25:0]     na;
    logic [34:0]     prod4;
    logic [26:0]     ra;
    logic [9:0]      a;
    ucd_pkg::days_t  b_next;
    logic [28:0]     nc;
    logic [45:0]     prod6;
    logic [28:0]     rc;
    logic [15:0]     c_fix;
    ucd_pkg::days_t  d_full;
    logic [25:0]     prod10;
    logic [20:0]     re;
    logic [5:0]      e_fix;

    always_comb
    begin
        na    = {days, 2'b00} + 26'(ucd_pkg::OFS_A);
        prod4 = 35'(na) * 35'(ucd_pkg::RCP_A);

        ra = 27'(na4_reg) - 27'(qa4_reg) * 27'(ucd_pkg::CYCLE_400);
        if (ra >= 27'(ucd_pkg::CYCLE_400))
        begin
            a = 10'(qa4_reg) + 10'd1 + 10'(ucd_pkg::OFS_A2);
        end
        else
        begin
            a = 10'(qa4_reg) + 10'(ucd_pkg::OFS_A2);
        end
        b_next = d4_reg + 24'(ucd_pkg::OFS_B) + 24'(a) - 24'(a >> 2);

        nc    = 29'(b5_reg) * 29'(20) - 29'(ucd_pkg::OFS_C);
        prod6 = 46'(nc) * 46'(ucd_pkg::RCP_C);

        rc = nc6_reg - 29'(qc6_reg) * 29'(ucd_pkg::DIV_C);
        if (rc >= 29'(ucd_pkg::DIV_C))
        begin
            c_fix = qc6_reg + 16'd1;
        end
        else
        begin
            c_fix = qc6_reg;
        end

        d_full = b7_reg - 24'(c7_reg) * 24'(365) - 24'(c7_reg >> 2);

        prod10 = 26'(ne9_reg) * 26'(ucd_pkg::RCP_E);
        re     = 21'(ne10_reg) - 21'(qe10_reg) * 21'(ucd_pkg::DIV_E);
        if (re >= 21'(ucd_pkg::DIV_E))
        begin
            e_fix = qe10_reg + 6'd1;
        end
        else
        begin
            e_fix = qe10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            na4_reg <= na;
            qa4_reg <= prod4[34:26];
            d4_reg  <= days;
        end
        if (en[5])
        begin
            b5_reg <= b_next;
        end
        if (en[6])
        begin
            nc6_reg <= nc;
            qc6_reg <= prod6[44:29];
            b6_reg  <= b5_reg;
        end
        if (en[7])
        begin
            c7_reg <= c_fix;
            b7_reg <= b6_reg;
        end
        if (en[8])
        begin
            dd8_reg <= d_full[9:0];
            c8_reg  <= c7_reg;
        end
        if (en[9])
        begin
            ne9_reg <= 20'(dd8_reg) * 20'(1000);
            dd9_reg <= dd8_reg;
            c9_reg  <= c8_reg;
        end
        if (en[10])
        begin
            ne10_reg <= ne9_reg;
            qe10_reg <= prod10[25:20];
            dd10_reg <= dd9_reg;
            c10_reg  <= c9_reg;
        end
        if (en[11])
        begin
            e11_reg  <= e_fix[3:0];
            dd11_reg <= dd10_reg;
            c11_reg  <= c10_reg;
        end
        if (en[12])
        begin
            if (e11_reg <= 4'(ucd_pkg::E_SPLIT))
            begin
                year_reg  <= c11_reg - 16'(ucd_pkg::YEAR_LO);
                month_reg <= e11_reg - 4'd1;
            end
            else
            begin
                year_reg  <= c11_reg - 16'(ucd_pkg::YEAR_HI);
                month_reg <= e11_reg - 4'(ucd_pkg::E_SPLIT);
            end
            day_reg <= 5'(dd11_reg - ucd_pkg::MONTH_OFS[e11_reg]);
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

### src/unix_seconds_to_civil_date.sv
// channel   signals                                   transfer when
// input     in_valid, in_ready, unix_seconds          in_valid && in_ready
// output    out_valid, out_ready, year, month, day,   out_valid && out_ready
//           hour, minute, sec
//
// 13-stage pipeline, one transfer per cycle each side while out_ready is held high;
// the constant-divisor multiplies set the stage cut
// each stage holds its item until the next stage has room, bubbles collapse
// rst_n clears only the stage valid bits

module unix_seconds_to_civil_date #(
    parameter int SECONDS_WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SECONDS_WIDTH-1:0] unix_seconds,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              year,
    output logic [3:0]               month,
    output logic [4:0]               day,
    output logic [4:0]               hour,
    output logic [5:0]               minute,
    output logic [5:0]               sec
);

    ucd_pkg::stage_en_t valid_reg;
    ucd_pkg::stage_en_t valid_next;
    ucd_pkg::stage_en_t en;
    ucd_pkg::secs_t     secs;
    ucd_pkg::days_t     days;
    ucd_pkg::sod_t      sod;
    ucd_pkg::hms_t      hms;

    assign secs = ucd_pkg::secs_t'(unix_seconds);

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        en[ucd_pkg::STAGES-1] = !valid_reg[ucd_pkg::STAGES-1] || out_ready;
        for (int i = ucd_pkg::STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < ucd_pkg::STAGES; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    ucd_day_split u_day_split (
        .clk  (clk),
        .en   (en),
        .secs (secs),
        .days (days),
        .sod  (sod)
    );

    ucd_clock_split u_clock_split (
        .clk (clk),
        .en  (en),
        .sod (sod),
        .hms (hms)
    );

    ucd_date_calc u_date_calc (
        .clk   (clk),
        .en    (en),
        .days  (days),
        .year  (year),
        .month (month),
        .day   (day)
    );

    assign in_ready  = en[0];
    assign out_valid = valid_reg[ucd_pkg::STAGES-1];
    assign hour      = hms.hour;
    assign minute    = hms.minute;
    assign sec       = hms.sec;

endmodule
